// ===== rtl/core/matrix4_inverse_macros.svh =====
// Assertion macros used by the matrix inverse datapath
`ifndef MATRIX4_INVERSE_MACROS_SVH
`define MATRIX4_INVERSE_MACROS_SVH
`ifndef SYNTH
// Check that the antecedent implies the consequent in the same cycle
`define MI4_CHK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Check that the antecedent implies the consequent in the next cycle
`define MI4_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MI4_CHK_IMP(lbl, ante, cons)
`define MI4_CHK_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/mi4_pkg.sv =====
// Types, constants and index tables for the 4x4 matrix inverse
`timescale 1ns / 1ps
package mi4_pkg;

    localparam int ELEM_W  = 32;
    localparam int IDX_W   = 4;
    localparam int QUO_W   = 32;
    // signed cofactor width: six triple products of 32-bit values
    localparam int ADJ_W   = 97;
    // accumulator width: holds the determinant exactly
    localparam int ACC_W   = 132;
    localparam int N_PERM  = 6;

    localparam logic [IDX_W-1:0] LAST_IDX  = 4'd15;
    localparam logic [2:0]       PERM_LAST = 3'd5;
    localparam logic [2:0]       PERM_NEG  = 3'd3;
    localparam logic [1:0]       CHUNK_TOP = 2'd3;
    localparam logic [1:0]       K_LAST    = 2'd3;
    localparam logic [ELEM_W-1:0] POS_LIM  = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] NEG_LIM  = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COF_E1,
        ST_COF_M2,
        ST_COF_E3,
        ST_COF_LO,
        ST_COF_HI,
        ST_COF_ACC,
        ST_COF_WR,
        ST_DET_E,
        ST_DET_M,
        ST_DET_A,
        ST_DET_END,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_EM,
        MUL_TLO,
        MUL_THI,
        MUL_ADJ
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ADD,
        ACC_SUB,
        ACC_CLEAR
    } acc_op_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;   // matrix store read address
        logic             e_load;    // operand register takes the store word
        mul_op_t          mul_op;
        logic [1:0]       chunk;     // cofactor word slice for MUL_ADJ
        logic             t_load;    // partial product register takes the product
        acc_op_t          acc_op;
        logic [1:0]       acc_shift; // product weight in 32-bit words
        logic [IDX_W-1:0] adj_addr;  // cofactor store address, also result index
        logic             adj_wr;
        logic             det_load;
        logic             div_init;
        logic             div_step;
        logic             div_first; // overflow probe step
        logic             out_load;
        logic             out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic singular;
        logic out_free;
    } dp_sts_t;

    // Store address of factor 'term' of product 'perm' of cofactor 'cof'
    function automatic logic [IDX_W-1:0] cof_addr(
        input logic [IDX_W-1:0] cof,
        input logic [2:0]       perm,
        input logic [1:0]       term
    );
        logic [5:0] slots;
        logic [1:0] slot;
        logic [1:0] row;
        logic [1:0] col;
        case (perm)
            3'd0:    slots = 6'b10_01_00;
            3'd1:    slots = 6'b00_10_01;
            3'd2:    slots = 6'b01_00_10;
            3'd3:    slots = 6'b01_10_00;
            3'd4:    slots = 6'b10_00_01;
            3'd5:    slots = 6'b00_01_10;
            default: slots = 6'b10_01_00;
        endcase
        case (term)
            2'd0:    slot = slots[1:0];
            2'd1:    slot = slots[3:2];
            default: slot = slots[5:4];
        endcase
        // skip row j (cof[1:0]) and column i (cof[3:2])
        row = (term >= cof[1:0]) ? term + 2'd1 : term;
        col = (slot >= cof[3:2]) ? slot + 2'd1 : slot;
        return {row, col};
    endfunction

endpackage

// ===== rtl/core/matrix4_inverse.sv =====
// Sequence: after the element at index 15, the cofactors, then the determinant, then each result
// in turn (an init, an overflow probe and one divider step per quotient bit, an issue).
// Singular matrix: the divider steps are skipped and each result is issued as zero.
// Throughput: elements load one per cycle; the input stalls from index 15 until the last
// result is in the output register. The shared 33x33 multiplier and divider set the figure.
// Reset: rst_n clears the sequencer and output valid; matrix contents stay undefined.
`timescale 1ns / 1ps
module matrix4_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element_value
    input  logic [3:0]  s_tuser,   // [3:0] element_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] out_value
    output logic [4:0]  m_tuser,   // [3:0] out_index, [4] singular
    output logic        m_tlast
);
    import mi4_pkg::*;

    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic             in_accept;
    logic [IDX_W-1:0] out_idx;
    logic             out_sing;

    assign in_accept = s_tvalid && s_tready;

    mi4_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .in_last_idx (s_tuser == LAST_IDX),
        .sts         (sts),
        .in_ready    (s_tready),
        .cmd         (cmd)
    );

    mi4_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_accept),
        .wr_addr   (s_tuser),
        .wr_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_idx   (out_idx),
        .out_val   (m_tdata),
        .out_sing  (out_sing),
        .out_last  (m_tlast)
    );

    assign m_tuser = {out_sing, out_idx};

endmodule

// ===== rtl/core/mi4_ctrl.sv =====
// Sequencer for cofactors, determinant, division and result issue
`timescale 1ns / 1ps
module mi4_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_accept,
    input  logic             in_last_idx,
    input  mi4_pkg::dp_sts_t sts,
    output logic             in_ready,
    output mi4_pkg::dp_cmd_t cmd
);
    import mi4_pkg::*;

    localparam logic [5:0] DIV_STEPS = 6'(QUO_W);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cof_reg, cof_next;
    logic [2:0]       perm_reg, perm_next;
    logic [1:0]       k_reg, k_next;
    logic [1:0]       chunk_reg, chunk_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             term_sub;

    // Sign of the current product: odd permutation xor cofactor checkerboard
    assign term_sub = (perm_reg >= PERM_NEG) ^ cof_reg[2] ^ cof_reg[0];
    assign in_ready = (state_reg == ST_IDLE);

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cof_reg   <= '0;
            perm_reg  <= '0;
            k_reg     <= '0;
            chunk_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cof_reg   <= cof_next;
            perm_reg  <= perm_next;
            k_reg     <= k_next;
            chunk_reg <= chunk_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        cof_next   = cof_reg;
        perm_next  = perm_reg;
        k_next     = k_reg;
        chunk_next = chunk_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && in_last_idx)
                begin
                    state_next = ST_COF_E1;
                    cof_next   = '0;
                    perm_next  = '0;
                end
            end
            ST_COF_E1:  state_next = ST_COF_M2;
            ST_COF_M2:  state_next = ST_COF_E3;
            ST_COF_E3:  state_next = ST_COF_LO;
            ST_COF_LO:  state_next = ST_COF_HI;
            ST_COF_HI:  state_next = ST_COF_ACC;
            ST_COF_ACC:
            begin
                if (perm_reg == PERM_LAST)
                begin
                    state_next = ST_COF_WR;
                    perm_next  = '0;
                end
                else
                begin
                    state_next = ST_COF_E1;
                    perm_next  = perm_reg + 3'd1;
                end
            end
            ST_COF_WR:
            begin
                cof_next = cof_reg + 4'd1;
                if (cof_reg == LAST_IDX)
                begin
                    state_next = ST_DET_E;
                    k_next     = '0;
                    chunk_next = '0;
                end
                else
                begin
                    state_next = ST_COF_E1;
                end
            end
            ST_DET_E:   state_next = ST_DET_M;
            ST_DET_M:   state_next = ST_DET_A;
            ST_DET_A:
            begin
                chunk_next = chunk_reg + 2'd1;
                if (chunk_reg != CHUNK_TOP)
                begin
                    state_next = ST_DET_M;
                end
                else if (k_reg == K_LAST)
                begin
                    state_next = ST_DET_END;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_DET_E;
                end
            end
            ST_DET_END:
            begin
                state_next = ST_DIV_INIT;
                cof_next   = '0;
            end
            ST_DIV_INIT:
            begin
                cnt_next   = DIV_STEPS;
                state_next = sts.singular ? ST_OUT : ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cof_next   = cof_reg + 4'd1;
                    state_next = (cof_reg == LAST_IDX) ? ST_IDLE : ST_DIV_INIT;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.acc_op = ACC_CLEAR;
            end
            ST_COF_E1:
            begin
                cmd.rd_addr = cof_addr(cof_reg, perm_reg, 2'd0);
                cmd.e_load  = 1'b1;
            end
            ST_COF_M2:
            begin
                cmd.rd_addr = cof_addr(cof_reg, perm_reg, 2'd1);
                cmd.mul_op  = MUL_EM;
            end
            ST_COF_E3:
            begin
                cmd.t_load  = 1'b1;
                cmd.rd_addr = cof_addr(cof_reg, perm_reg, 2'd2);
                cmd.e_load  = 1'b1;
            end
            ST_COF_LO:
            begin
                cmd.mul_op = MUL_TLO;
            end
            ST_COF_HI:
            begin
                cmd.acc_op    = term_sub ? ACC_SUB : ACC_ADD;
                cmd.acc_shift = 2'd0;
                cmd.mul_op    = MUL_THI;
            end
            ST_COF_ACC:
            begin
                cmd.acc_op    = term_sub ? ACC_SUB : ACC_ADD;
                cmd.acc_shift = 2'd1;
            end
            ST_COF_WR:
            begin
                cmd.adj_wr   = 1'b1;
                cmd.adj_addr = cof_reg;
                cmd.acc_op   = ACC_CLEAR;
            end
            ST_DET_E:
            begin
                cmd.rd_addr = {2'b00, k_reg};
                cmd.e_load  = 1'b1;
            end
            ST_DET_M:
            begin
                cmd.mul_op   = MUL_ADJ;
                cmd.chunk    = chunk_reg;
                cmd.adj_addr = {k_reg, 2'b00};
            end
            ST_DET_A:
            begin
                cmd.acc_op    = ACC_ADD;
                cmd.acc_shift = chunk_reg;
            end
            ST_DET_END:
            begin
                cmd.det_load = 1'b1;
                cmd.acc_op   = ACC_CLEAR;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cmd.adj_addr = cof_reg;
            end
            ST_DIV_STEP:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == DIV_STEPS);
            end
            ST_OUT:
            begin
                cmd.adj_addr = cof_reg;
                cmd.out_load = sts.out_free;
                cmd.out_last = (cof_reg == LAST_IDX);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/mi4_dp.sv =====
// Datapath: matrix store, shared multiplier, accumulator, divider, output register
`timescale 1ns / 1ps
`include "matrix4_inverse_macros.svh"
module mi4_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [mi4_pkg::IDX_W-1:0]         wr_addr,
    input  logic [mi4_pkg::ELEM_W-1:0]        wr_data,
    input  mi4_pkg::dp_cmd_t                  cmd,
    output mi4_pkg::dp_sts_t                  sts,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [mi4_pkg::IDX_W-1:0]         out_idx,
    output logic [mi4_pkg::ELEM_W-1:0]        out_val,
    output logic                              out_sing,
    output logic                              out_last
);
    import mi4_pkg::*;

    localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;
    localparam int DIV_W = (NUM_W > ACC_W + QUO_W) ? NUM_W : ACC_W + QUO_W;
    localparam int PROD_W = 2 * (ELEM_W + 1);
    localparam int EXT_W = 4 * ELEM_W;

    logic [ELEM_W-1:0]        mem [16];
    logic [ELEM_W-1:0]        rd_data;
    logic signed [ELEM_W-1:0] e_reg;
    logic [2*ELEM_W-1:0]      t_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ELEM_W:0]   mul_a, mul_b;
    logic [ADJ_W-1:0]         adj_mem [16];
    logic [ADJ_W-1:0]         adj_rd;
    logic [EXT_W-1:0]         adj_ext;
    logic [ELEM_W-1:0]        adj_chunk;
    logic signed [ACC_W-1:0]  acc_reg, p_ext, p_shift;
    logic [ACC_W-1:0]         acc_abs;
    logic [ACC_W-1:0]         det_mag_reg;
    logic                     det_neg_reg;
    logic                     sing_reg;
    logic [ADJ_W-1:0]         adj_abs;
    logic [DIV_W-1:0]         rem_reg, d_reg;
    logic [DIV_W:0]           diff;
    logic                     ge;
    logic [QUO_W-1:0]         q_reg;
    logic                     sat_reg, neg_reg;
    logic [ELEM_W-1:0]        res;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic [ELEM_W-1:0]        out_val_reg;
    logic                     out_sing_reg, out_last_reg;

    // Matrix store: written from the input channel
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end
    assign rd_data = mem[cmd.rd_addr];

    // Cofactor word slices, sign-extended, top slice signed
    assign adj_rd  = adj_mem[cmd.adj_addr];
    assign adj_ext = {{(EXT_W - ADJ_W){adj_rd[ADJ_W-1]}}, adj_rd};
    always_comb
    begin
        case (cmd.chunk)
            2'd0:    adj_chunk = adj_ext[ELEM_W-1:0];
            2'd1:    adj_chunk = adj_ext[2*ELEM_W-1:ELEM_W];
            2'd2:    adj_chunk = adj_ext[3*ELEM_W-1:2*ELEM_W];
            default: adj_chunk = adj_ext[4*ELEM_W-1:3*ELEM_W];
        endcase
    end

    // Select multiplier operands
    always_comb
    begin
        mul_b = {e_reg[ELEM_W-1], e_reg};
        case (cmd.mul_op)
            MUL_EM:
            begin
                mul_a = {e_reg[ELEM_W-1], e_reg};
                mul_b = {rd_data[ELEM_W-1], rd_data};
            end
            MUL_TLO: mul_a = {1'b0, t_reg[ELEM_W-1:0]};
            MUL_THI: mul_a = {t_reg[2*ELEM_W-1], t_reg[2*ELEM_W-1:ELEM_W]};
            MUL_ADJ:
            begin
                mul_a = (cmd.chunk == CHUNK_TOP) ? {adj_chunk[ELEM_W-1], adj_chunk}
                                                 : {1'b0, adj_chunk};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Operand, product and partial product registers
    always_ff @(posedge clk)
    begin
        if (cmd.e_load)
        begin
            e_reg <= rd_data;
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.t_load)
        begin
            t_reg <= prod_reg[2*ELEM_W-1:0];
        end
    end

    // Accumulate weighted products
    assign p_ext   = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign p_shift = p_ext << {cmd.acc_shift, 5'b00000};
    always_ff @(posedge clk)
    begin
        case (cmd.acc_op)
            ACC_ADD:   acc_reg <= acc_reg + p_shift;
            ACC_SUB:   acc_reg <= acc_reg - p_shift;
            ACC_CLEAR: acc_reg <= '0;
            default:   acc_reg <= acc_reg;
        endcase
        if (cmd.adj_wr)
        begin
            adj_mem[cmd.adj_addr] <= acc_reg[ADJ_W-1:0];
        end
    end

    // Capture determinant magnitude and sign
    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sing_reg <= 1'b0;
        end
        else if (cmd.det_load)
        begin
            sing_reg <= (acc_reg == '0);
        end
    end
    always_ff @(posedge clk)
    begin
        if (cmd.det_load)
        begin
            det_mag_reg <= acc_abs;
            det_neg_reg <= acc_reg[ACC_W-1];
        end
    end

    // Restoring division, one quotient bit per step after an overflow probe
    assign adj_abs = adj_rd[ADJ_W-1] ? -adj_rd : adj_rd;
    assign diff    = {1'b0, rem_reg} - {1'b0, d_reg};
    assign ge      = ~diff[DIV_W];
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= DIV_W'(adj_abs) << (2 * FRAC_BITS);
            d_reg   <= DIV_W'(det_mag_reg) << QUO_W;
            neg_reg <= adj_rd[ADJ_W-1] ^ det_neg_reg;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= diff[DIV_W-1:0];
            end
            if (cmd.div_first)
            begin
                sat_reg <= ge;
            end
            else
            begin
                q_reg <= {q_reg[QUO_W-2:0], ge};
            end
            d_reg <= d_reg >> 1;
        end
    end

    // Apply sign and saturation
    always_comb
    begin
        if (sing_reg)
        begin
            res = '0;
        end
        else if (neg_reg)
        begin
            res = (sat_reg || (q_reg > NEG_LIM)) ? NEG_LIM : -q_reg;
        end
        else
        begin
            res = (sat_reg || q_reg[QUO_W-1]) ? POS_LIM : q_reg;
        end
    end

    // Output register: hold a transaction until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_idx_reg  <= cmd.adj_addr;
            out_val_reg  <= res;
            out_sing_reg <= sing_reg;
            out_last_reg <= cmd.out_last;
        end
    end

    assign sts.singular = sing_reg;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_idx      = out_idx_reg;
    assign out_val      = out_val_reg;
    assign out_sing     = out_sing_reg;
    assign out_last     = out_last_reg;

    `MI4_CHK_IMP(a_load_free, cmd.out_load, !out_valid_reg || out_ready)
    `MI4_CHK_NEXT(a_sing_zero, cmd.out_load && sing_reg, out_val_reg == '0)
    `MI4_CHK_IMP(a_last_idx, out_valid_reg && out_last_reg, out_idx_reg == LAST_IDX)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the 4x4 fixed-point matrix inverse
`timescale 1ns / 1ps
module tb;

    localparam int FRAC      = 16;
    localparam int N_ITEMS   = 280;
    localparam int QUIET_AT  = 230;
    localparam int CYC_LIMIT = 2000000;
    localparam int HOLD_OFF  = 3000;

    typedef logic signed [199:0] wide_t;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] value;
        logic        singular;
        logic        last;
    } inv_elem_t;

    // Inverse predictor and queue of pending inverse elements
    class inverse_scoreboard;
        logic signed [31:0] mat[16];
        inv_elem_t          pending[$];
        int                 errors;

        function new();
            errors = 0;
            foreach (mat[k]) mat[k] = '0;
        endfunction

        function wide_t el(int r, int c);
            wide_t w;
            w = mat[r * 4 + c];
            return w;
        endfunction

        // signed minor with row j and column i removed, times the checkerboard sign
        function wide_t cofactor(int i, int j);
            int    rs[3];
            int    cs[3];
            int    n;
            int    m;
            wide_t s;
            n = 0;
            m = 0;
            for (int k = 0; k < 4; k++)
            begin
                if (k != j) rs[n++] = k;
                if (k != i) cs[m++] = k;
            end
            s = el(rs[0], cs[0]) * (el(rs[1], cs[1]) * el(rs[2], cs[2])
                                  - el(rs[1], cs[2]) * el(rs[2], cs[1]))
              - el(rs[0], cs[1]) * (el(rs[1], cs[0]) * el(rs[2], cs[2])
                                  - el(rs[1], cs[2]) * el(rs[2], cs[0]))
              + el(rs[0], cs[2]) * (el(rs[1], cs[0]) * el(rs[2], cs[1])
                                  - el(rs[1], cs[1]) * el(rs[2], cs[0]));
            return ((i + j) % 2 == 1) ? -s : s;
        endfunction

        // Store the element; on the last index predict the whole inverse
        function void note_input(logic [3:0] idx, logic [31:0] val);
            wide_t     adj[16];
            wide_t     det;
            wide_t     q;
            inv_elem_t e;
            mat[idx] = val;
            if (idx != 4'd15) return;
            for (int k = 0; k < 16; k++) adj[k] = cofactor(k / 4, k % 4);
            det = '0;
            for (int k = 0; k < 4; k++) det += el(0, k) * adj[k * 4];
            for (int k = 0; k < 16; k++)
            begin
                e.idx      = k[3:0];
                e.singular = (det == 0);
                e.last     = (k == 15);
                if (det == 0)
                    e.value = '0;
                else
                begin
                    q = (adj[k] <<< (2 * FRAC)) / det;
                    if (q > wide_t'(32'sh7FFF_FFFF))       e.value = 32'h7FFF_FFFF;
                    else if (q < -wide_t'(64'sh8000_0000)) e.value = 32'h8000_0000;
                    else                                   e.value = q[31:0];
                end
                pending.push_back(e);
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        endtask

        task check(logic [3:0] idx, logic [31:0] val, logic sing, logic lst);
            inv_elem_t e;
            if (pending.size() == 0)
            begin
                report("unexpected transaction", val, '0);
                return;
            end
            e = pending.pop_front();
            if (idx !== e.idx)       report("out_index", 32'(idx), 32'(e.idx));
            if (val !== e.value)     report("out_value", val, e.value);
            if (sing !== e.singular) report("singular", 32'(sing), 32'(e.singular));
            if (lst !== e.last)      report("last", 32'(lst), 32'(e.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    inverse_scoreboard sb;
    int                sent;
    bit                quiet;
    bit                hold_done;
    int                cycles;

    matrix4_inverse #(.FRAC_BITS(FRAC)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tuser[3:0], m_tdata, m_tuser[4], m_tlast);
    end

    // Random element value across magnitude classes
    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 6))
            0:       return $urandom;
            1:       return $urandom_range(0, 15) << FRAC;
            2:       return -($urandom_range(1, 15) << FRAC);
            3:       return $urandom_range(0, 255);
            4:       return '0;
            5:       return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // Offer one element and hold until it is accepted
    task send_item(logic [3:0] idx, logic [31:0] val);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= idx;
        s_tdata  <= val;
        do @(posedge clk); while (!s_tready);
        sb.note_input(idx, val);
        sent++;
        if (sent >= QUIET_AT) quiet = 1'b1;
    endtask

    // Load a whole matrix in random order, index 15 last
    task load_matrix(bit dup_row);
        int order[15];
        foreach (order[k]) order[k] = k;
        order.shuffle();
        foreach (order[k])
        begin
            if (dup_row && order[k] >= 12)
                send_item(order[k][3:0], sb.mat[order[k] - 12]);
            else
                send_item(order[k][3:0], rand_elem());
        end
        send_item(4'd15, dup_row ? sb.mat[3] : rand_elem());
    endtask

    // Pause the sender until every pending result has arrived
    task drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    // Receiver: random stall bursts and one long hold-off
    initial
    begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent >= 60)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        sb       = new();
        cycles   = 0;
        sent     = 0;
        quiet    = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity
        for (int k = 0; k < 16; k++)
            send_item(k[3:0], (k % 5 == 0) ? (32'd1 << FRAC) : 32'd0);
        // tiny and negative diagonal: saturate both ways
        send_item(4'd0, 32'd1);
        send_item(4'd5, 32'hFFFF_FFFF);
        send_item(4'd15, 32'd1 << FRAC);
        // extreme element values
        send_item(4'd10, 32'h8000_0000);
        send_item(4'd15, 32'h7FFF_FFFF);
        drain();
        // zero first row: singular
        for (int k = 0; k < 4; k++) send_item(k[3:0], '0);
        send_item(4'd15, 32'd3 << FRAC);

        while (sent < N_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: load_matrix(1'b0);
                4:          load_matrix(1'b1);
                5, 6:
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(4'($urandom_range(0, 14)), rand_elem());
                    send_item(4'd15, rand_elem());
                end
                7:          drain();
                default:    send_item(4'($urandom_range(0, 14)), rand_elem());
            endcase
        end
        send_item(4'd15, rand_elem());

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
